// ----- rtl/csl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package csl_pkg;

    localparam int PHASE_BITS_DEF = 32;
    localparam int PERIOD_BITS_DEF = 32;
    localparam int SINE_DEPTH_DEF = 256;
    localparam int FULL_SCALE = 10240;
    localparam int NUM_BITS = 7;
    localparam int DEN_BITS = 7;
    localparam int IDX_MAX = 26;

    localparam logic [1:0] REG_OFFSET_MODE = 2'd0;
    localparam logic [1:0] REG_HOLD_FREEZE = 2'd1;
    localparam logic [1:0] REG_HOLD_LATCHED = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_WAVE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;

    function automatic logic [NUM_BITS-1:0] ratio_num(input logic [4:0] idx);
        logic [NUM_BITS-1:0] r;
        case (idx)
            5'd12: r = 7'd2;
            5'd14: r = 7'd3;
            5'd15: r = 7'd2;
            5'd16: r = 7'd3;
            5'd17: r = 7'd4;
            5'd18: r = 7'd5;
            5'd19: r = 7'd6;
            5'd20: r = 7'd7;
            5'd21: r = 7'd8;
            5'd22: r = 7'd11;
            5'd23: r = 7'd13;
            5'd24: r = 7'd16;
            5'd25: r = 7'd32;
            5'd26: r = 7'd64;
            default: r = 7'd1;
        endcase
        return r;
    endfunction

    function automatic logic [DEN_BITS-1:0] ratio_den(input logic [4:0] idx);
        logic [DEN_BITS-1:0] r;
        case (idx)
            5'd0: r = 7'd64;
            5'd1: r = 7'd32;
            5'd2: r = 7'd16;
            5'd3: r = 7'd13;
            5'd4: r = 7'd11;
            5'd5: r = 7'd8;
            5'd6: r = 7'd7;
            5'd7: r = 7'd6;
            5'd8: r = 7'd5;
            5'd9: r = 7'd4;
            5'd10: r = 7'd3;
            5'd11: r = 7'd2;
            5'd12: r = 7'd3;
            5'd14: r = 7'd2;
            default: r = 7'd1;
        endcase
        return r;
    endfunction

    // fixed series sine, evaluated at elaboration only
    // lg is log2 of the table depth
    function automatic logic [15:0] qsine(input int i, input int lg);
        longint unsigned x, x2, term, sum;
        x = (64'd1686629713 * longint'(i) + (64'd1 << (lg - 1))) >> lg;
        x2 = (x * x) >> 30;
        term = x;
        sum = x;
        term = ((term * x2) >> 30) / 64'd6;
        sum = sum - term;
        term = ((term * x2) >> 30) / 64'd20;
        sum = sum + term;
        term = ((term * x2) >> 30) / 64'd42;
        sum = sum - term;
        term = ((term * x2) >> 30) / 64'd72;
        sum = sum + term;
        term = ((term * x2) >> 30) / 64'd110;
        sum = sum - term;
        term = ((term * x2) >> 30) / 64'd156;
        sum = sum + term;
        term = ((term * x2) >> 30) / 64'd210;
        sum = sum - term;
        return 16'((sum * 10240 + (64'd1 << 29)) >> 30);
    endfunction

endpackage
`default_nettype wire

// ----- rtl/csl_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module csl_div import csl_pkg::*; #(
    parameter int PHASE_BITS = PHASE_BITS_DEF,
    parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic [NUM_BITS-1:0] num,
    input  wire logic [PERIOD_BITS+DEN_BITS-1:0] divisor,
    output div_ctl_t ctl,
    output logic [PHASE_BITS-1:0] inc
);
    localparam int DW = PERIOD_BITS + DEN_BITS;
    localparam int QW = NUM_BITS + PHASE_BITS;
    localparam int CW = $clog2(QW + 1);
    localparam logic [PHASE_BITS-1:0] CAP = PHASE_BITS'(1) << (PHASE_BITS - 1);

    logic [QW-1:0] quo_reg, quo_next;
    logic [DW:0] rem_reg, rem_next;
    logic [DW-1:0] dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next, done_reg, done_next;
    logic [DW:0] trial;

    // restoring divide, one quotient bit a cycle
    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg[DW-1:0], quo_reg[QW-1]};
        if (start)
        begin
            quo_next = {num, PHASE_BITS'(0)};
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = CW'(QW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign ctl.start = start;
    assign ctl.busy = busy_reg;
    assign ctl.done = done_reg;
    assign inc = (dvs_reg == '0) ? '0 :
        ((quo_reg > QW'(CAP)) ? CAP : quo_reg[PHASE_BITS-1:0]);
endmodule
`default_nettype wire

// ----- rtl/csl_wave.sv -----
`timescale 1ns / 1ps
`default_nettype none
module csl_wave import csl_pkg::*; #(
    parameter int PHASE_BITS = PHASE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
    input  wire logic [PHASE_BITS-1:0] ph,
    input  wire logic offset_mode,
    output logic signed [15:0] sine,
    output logic signed [15:0] tri_w,
    output logic signed [15:0] saw,
    output logic signed [15:0] sqr
);
    localparam int AB = $clog2(SINE_TABLE_DEPTH);
    localparam int PW = AB + 2;
    localparam int SW = PHASE_BITS + 16;

    logic [15:0] qtab [SINE_TABLE_DEPTH+1];
    for (genvar gi = 0; gi <= SINE_TABLE_DEPTH; gi++)
    begin : g_tab
        localparam logic [15:0] QV = qsine(gi, AB);
        assign qtab[gi] = QV;
    end

    logic [PW-1:0] pos;
    logic [AB-1:0] k;
    logic [AB:0] addr;
    logic [1:0] q;
    logic [15:0] v;
    logic [PHASE_BITS-1:0] sh, f, g, d;
    logic [SW-1:0] sawp, trip;
    logic half;

    always_comb
    begin
        pos = ph[PHASE_BITS-1 -: PW] + (offset_mode ? PW'(SINE_TABLE_DEPTH) : PW'(0));
        q = pos[PW-1 -: 2];
        k = pos[AB-1:0];
        addr = q[0] ? ((AB+1)'(SINE_TABLE_DEPTH) - {1'b0, k}) : {1'b0, k};
        v = qtab[addr];
        half = ph[PHASE_BITS-1];
        sh = ph + (PHASE_BITS'(1) << (PHASE_BITS - 2));
        f = offset_mode ? ph : sh;
        g = '0 - f;
        d = (f < g) ? f : g;
        sawp = (SW'(ph) * SW'(20480)) >> PHASE_BITS;
        trip = (SW'(d) * SW'(40960)) >> PHASE_BITS;
        if (offset_mode)
        begin
            sine = q[1] ? 16'(FULL_SCALE) + $signed(v) : 16'(FULL_SCALE) - $signed(v);
            tri_w = $signed(trip[15:0]);
            saw = $signed(sawp[15:0]);
            sqr = half ? 16'sd0 : 16'sd20480;
        end
        else
        begin
            sine = q[1] ? -$signed(v) : $signed(v);
            tri_w = $signed(trip[15:0]) - 16'sd10240;
            saw = half ? $signed(sawp[15:0]) - 16'sd20480 : $signed(sawp[15:0]);
            sqr = half ? -16'sd10240 : 16'sd10240;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/clock_synced_lfo_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Tempo-synced LFO. Each input beat is one sample tick; its result beat is formed
// in the states MUL, DIV, WAVE and OUT, using the bit-serial divider that forms
// ratio/period one quotient bit per cycle.
// in_stall is high while an item is in work or its result waits to be taken.
module clock_synced_lfo_core import csl_pkg::*; #(
    parameter int PHASE_BITS = PHASE_BITS_DEF,
    parameter int PERIOD_BITS = PERIOD_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [0:0] cfg_data,
    input  wire logic in_valid,
    output logic in_stall,
    input  wire logic clock_level,
    input  wire logic clock_connected,
    input  wire logic reset_level,
    input  wire logic reset_connected,
    input  wire logic hold_level,
    input  wire logic hold_connected,
    input  wire logic [4:0] division_index,
    output logic out_valid,
    input  wire logic out_stall,
    output logic signed [15:0] sine_out,
    output logic signed [15:0] triangle_out,
    output logic signed [15:0] saw_out,
    output logic signed [15:0] square_out,
    output logic clock_lamp,
    output logic hold_lamp,
    output logic [15:0] phase_out
);
    localparam int DW = PERIOD_BITS + DEN_BITS;

    state_t state_reg, state_next;
    logic offs_reg, frz_reg, lat_reg;
    logic [PERIOD_BITS-1:0] ticks_reg, per_reg;
    logic first_reg, hold_reg, pclk_reg, prst_reg, phld_reg, clamp_reg, hlamp_reg;
    logic [PHASE_BITS-1:0] ph_reg;
    logic [4:0] idx_reg;
    logic [15:0] w0_reg, w1_reg, w2_reg, w3_reg;
    logic ov_reg;
    logic [DW-1:0] prod_reg;
    logic div_start;
    div_ctl_t dctl;
    logic [PHASE_BITS-1:0] inc;
    logic signed [15:0] s_w, t_w, a_w, q_w;
    logic accept;
    logic [PERIOD_BITS-1:0] t1;
    logic [4:0] idx_c;

    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign t1 = (ticks_reg == '1) ? ticks_reg : ticks_reg + 1'b1;
    assign idx_c = (division_index > 5'(IDX_MAX)) ? 5'(IDX_MAX) : division_index;

    csl_div #(.PHASE_BITS(PHASE_BITS), .PERIOD_BITS(PERIOD_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .num(ratio_num(idx_reg)), .divisor(prod_reg), .ctl(dctl), .inc(inc)
    );

    csl_wave #(.PHASE_BITS(PHASE_BITS), .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_wave (
        .ph(ph_reg), .offset_mode(offs_reg),
        .sine(s_w), .tri_w(t_w), .saw(a_w), .sqr(q_w)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_MUL;
            ST_MUL: state_next = ST_DIV;
            ST_DIV: if (dctl.done) state_next = ST_WAVE;
            ST_WAVE: state_next = ST_OUT;
            ST_OUT: if (!out_stall) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        div_start = (state_reg == ST_DIV) && !dctl.busy && !dctl.done;
        out_valid = (state_reg == ST_OUT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            offs_reg <= 1'b1;
            frz_reg <= 1'b1;
            lat_reg <= 1'b1;
            ticks_reg <= '0;
            per_reg <= '0;
            first_reg <= 1'b0;
            hold_reg <= 1'b0;
            pclk_reg <= 1'b1;
            prst_reg <= 1'b1;
            phld_reg <= 1'b1;
            clamp_reg <= 1'b0;
            hlamp_reg <= 1'b0;
            ph_reg <= '0;
            w0_reg <= '0;
            w1_reg <= '0;
            w2_reg <= '0;
            w3_reg <= '0;
            ov_reg <= 1'b0;
            idx_reg <= '0;
            prod_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_OFFSET_MODE: offs_reg <= cfg_data[0];
                    REG_HOLD_FREEZE: frz_reg <= cfg_data[0];
                    REG_HOLD_LATCHED: lat_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (accept)
            begin
                idx_reg <= idx_c;
                ticks_reg <= t1;
                if (clock_connected)
                begin
                    pclk_reg <= clock_level;
                    if (clock_level && !pclk_reg)
                    begin
                        if (first_reg)
                            per_reg <= t1;
                        ticks_reg <= '0;
                        first_reg <= 1'b1;
                        clamp_reg <= 1'b0;
                    end
                    else
                        clamp_reg <= {t1, 1'b0} > {1'b0, per_reg};
                end
                if (reset_connected)
                begin
                    prst_reg <= reset_level;
                    if (reset_level && !prst_reg)
                        ph_reg <= '0;
                end
                if (hold_connected)
                begin
                    if (lat_reg)
                    begin
                        phld_reg <= hold_level;
                        if (hold_level && !phld_reg)
                        begin
                            hold_reg <= !hold_reg;
                            hlamp_reg <= !hold_reg;
                        end
                        else
                            hlamp_reg <= hold_reg;
                    end
                    else
                    begin
                        hold_reg <= hold_level;
                        hlamp_reg <= hold_level;
                    end
                end
            end
            if (state_reg == ST_MUL)
                prod_reg <= DW'(ratio_den(idx_reg)) * DW'(per_reg);
            if (state_reg == ST_DIV && dctl.done && (!hold_reg || !frz_reg))
                ph_reg <= ph_reg + inc;
            if (state_reg == ST_WAVE && !hold_reg)
            begin
                w0_reg <= s_w;
                w1_reg <= t_w;
                w2_reg <= a_w;
                w3_reg <= q_w;
            end
            ov_reg <= dctl.busy;
        end
    end

    assign sine_out = w0_reg;
    assign triangle_out = w1_reg;
    assign saw_out = w2_reg;
    assign square_out = w3_reg;
    assign clock_lamp = clamp_reg;
    assign hold_lamp = hlamp_reg;
    assign phase_out = ph_reg[PHASE_BITS-1 -: 16];
    logic unused_ok;
    assign unused_ok = ov_reg ^ dctl.start;
endmodule
`default_nettype wire

// ----- rtl/csl_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module csl_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_stall,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire logic [15:0] square_out,
    input wire logic [15:0] phase_out
);
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("input taken while result pending");
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall) else $error("not busy after beat");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid && $stable(square_out) && $stable(phase_out))
        else $error("stalled result changed");
    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> !out_valid) else $error("result repeated");
endmodule

bind clock_synced_lfo_core csl_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .square_out(square_out), .phase_out(phase_out)
);
`default_nettype wire
